[rtl/core/gbn_pkg.sv]
// Shared types, constants and helpers for the go-back-n sender.
// No dependencies; every other file in this folder imports it.
package gbn_pkg;

  localparam int PAYLOAD_WORDS = 5;
  localparam int IDX_W         = 3;
  localparam int WORD_W        = 32;
  localparam int TIMER_W       = 16;

  // Input item kinds
  localparam logic [1:0] OP_MSG  = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Register indexes
  localparam logic CFG_WINDOW  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD = 2'd0;
  localparam alu_op_t ALU_SUB = 2'd1;
  localparam alu_op_t ALU_INC = 2'd2;

  typedef struct packed {
    alu_op_t             op;
    logic [WORD_W-1:0]   a;
    logic [WORD_W-1:0]   b;
  } alu_req_t;

  // Sum of the four bytes of a word
  function automatic logic [9:0] bytes_of(input logic [WORD_W-1:0] w);
    bytes_of = 10'(w[7:0]) + 10'(w[15:8]) + 10'(w[23:16]) + 10'(w[31:24]);
  endfunction

endpackage

[rtl/core/go_back_n_sender.sv]
// Go-back-n sender. in_stall is high while an item is worked on: a plain message
// or ack word is stored and added to the running sum; the word that completes a
// message claims a window slot, then stores and emits the packet word by word, or
// drops it when the window is full; a completed ack has its sum and window
// range checked and slides the window; a tick advances the timer and on expiry
// resends each outstanding packet via the one memory read port; out_stall holds
// both sends. Sum, sequence, ack and timer steps use one shared 32-bit adder,
// one step per cycle. A finished result waits in the output register while the
// next item is accepted. The packet memory is not cleared; no start-up pass.
module go_back_n_sender import gbn_pkg::*; #(
  parameter int MAX_WINDOW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [31:0]         payload_word,
  input  logic                word_last,
  input  logic signed [31:0]  ack_seq_field,
  input  logic signed [31:0]  ack_number,
  input  logic signed [31:0]  ack_checksum,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [30:0]         seq_number,
  output logic signed [31:0]  packet_checksum,
  output logic [31:0]         out_payload_word,
  output logic [2:0]          word_index,
  output logic                packet_end,
  output logic                run_end
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DEPTH  = MAX_WINDOW * PAYLOAD_WORDS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_WORDS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TAKE  = 4'd1;
  localparam logic [3:0] S_MSG   = 4'd2;
  localparam logic [3:0] S_SEND  = 4'd3;
  localparam logic [3:0] S_ACK1  = 4'd4;
  localparam logic [3:0] S_ACK2  = 4'd5;
  localparam logic [3:0] S_ACK3  = 4'd6;
  localparam logic [3:0] S_ACK4  = 4'd7;
  localparam logic [3:0] S_TICK  = 4'd8;
  localparam logic [3:0] S_RADDR = 4'd9;
  localparam logic [3:0] S_RDATA = 4'd10;

  logic [3:0]          state;
  logic [3:0]          win_limit;
  logic [15:0]         timeout_ticks;
  logic [1:0]          op_r;
  logic [31:0]         word_r;
  logic                last_r;
  logic [31:0]         aseq_r, anum_r, achk_r;
  logic [31:0]         window_base, next_sequence, running_sum, tmp, seq_r;
  logic [IDX_W-1:0]    word_counter, idx;
  logic [CNT_W-1:0]    outstanding, remaining;
  logic [SLOT_W-1:0]   head_slot, cur_slot;
  logic [TIMER_W-1:0]  timer_count;
  logic                timer_running;
  logic [31:0]         msg_buf [PAYLOAD_WORDS];
  logic [31:0]         packet_sums [MAX_WINDOW];

  alu_req_t            alu_req;
  logic [31:0]         alu_res;
  logic                out_free, in_acc, room, d_ok, expired, emit;
  logic [SUM_W-1:0]    slot_sum, head_sum;
  logic [SLOT_W-1:0]   new_slot, new_head, slot_inc;
  logic [TIMER_W-1:0]  timer_inc;
  logic [ADDR_W-1:0]   mem_addr;
  logic [31:0]         send_word, rd_data;
  logic                wr_en, rd_en;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign emit     = ((state == S_SEND) || (state == S_RDATA)) && out_free;

  gbn_alu u_alu (.req(alu_req), .result(alu_res));

  gbn_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(mem_addr), .wr_data(send_word),
    .rd_en(rd_en), .rd_addr(mem_addr), .rd_data(rd_data)
  );

  // Steer the shared adder
  always_comb begin
    alu_req = '{op: ALU_ADD, a: running_sum, b: 32'(bytes_of(word_r))};
    unique case (state)
      S_MSG:   alu_req = '{op: ALU_ADD, a: next_sequence, b: running_sum};
      S_SEND:  alu_req = '{op: ALU_INC, a: next_sequence, b: '0};
      S_ACK1:  alu_req = '{op: ALU_ADD, a: aseq_r, b: anum_r};
      S_ACK2:  alu_req = '{op: ALU_ADD, a: tmp, b: running_sum};
      S_ACK3:  alu_req = '{op: ALU_SUB, a: anum_r, b: window_base};
      S_ACK4:  alu_req = '{op: ALU_INC, a: anum_r, b: '0};
      S_TICK:  alu_req = '{op: ALU_INC, a: 32'(timer_count), b: '0};
      S_RDATA: alu_req = '{op: ALU_INC, a: seq_r, b: '0};
      default: alu_req = '{op: ALU_ADD, a: running_sum, b: 32'(bytes_of(word_r))};
    endcase
  end

  // Window room, slot arithmetic, ack range and timer expiry
  assign room = (32'(outstanding) < 32'(win_limit)) &&
                (32'(outstanding) < 32'(MAX_WINDOW));
  assign slot_sum = SUM_W'(head_slot) + SUM_W'(outstanding);
  assign new_slot = (slot_sum >= SUM_W'(MAX_WINDOW)) ?
                    SLOT_W'(slot_sum - SUM_W'(MAX_WINDOW)) : SLOT_W'(slot_sum);
  assign head_sum = SUM_W'(head_slot) + SUM_W'(tmp[CNT_W-1:0]) + SUM_W'(1);
  assign new_head = (head_sum >= SUM_W'(MAX_WINDOW)) ?
                    SLOT_W'(head_sum - SUM_W'(MAX_WINDOW)) : SLOT_W'(head_sum);
  assign slot_inc = (32'(cur_slot) + 32'd1 >= 32'(MAX_WINDOW)) ? '0 : cur_slot + SLOT_W'(1);
  assign d_ok = (alu_res >> CNT_W) == 32'd0 && alu_res[CNT_W-1:0] < outstanding;
  assign timer_inc = alu_res[TIMER_W-1:0];
  assign expired = (timer_inc >= timeout_ticks) || (timer_inc == '0);

  // Memory access: write while sending a new packet, read while resending
  assign mem_addr  = ADDR_W'(cur_slot) * ADDR_W'(PAYLOAD_WORDS) + ADDR_W'(idx);
  assign send_word = (idx < word_counter) ? msg_buf[idx] : 32'd0;
  assign wr_en     = (state == S_SEND) && out_free;
  assign rd_en     = (state == S_RADDR);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_limit     <= 4'd8;
      timeout_ticks <= 16'd20;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW:  win_limit     <= cfg_data[3:0];
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        default:     win_limit     <= win_limit;
      endcase
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= operation;
      word_r <= payload_word;
      last_r <= word_last;
      aseq_r <= ack_seq_field;
      anum_r <= ack_number;
      achk_r <= ack_checksum;
    end
  end

  // Raise valid on each word sent, hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_base   <= '0;
      next_sequence <= '0;
      running_sum   <= '0;
      word_counter  <= '0;
      outstanding   <= '0;
      head_slot     <= '0;
      timer_count   <= '0;
      timer_running <= 1'b0;
      idx           <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_TAKE;
          end
        end
        // Assemble one word
        S_TAKE: begin
          if ((op_r == OP_MSG || op_r == OP_ACK) &&
              32'(word_counter) < 32'(PAYLOAD_WORDS)) begin
            msg_buf[word_counter] <= word_r;
            running_sum           <= alu_res;
            word_counter          <= word_counter + IDX_W'(1);
          end
          if (op_r == OP_MSG && last_r) begin
            state <= S_MSG;
          end else if (op_r == OP_ACK && last_r) begin
            state <= S_ACK1;
          end else if (op_r == OP_TICK) begin
            state <= S_TICK;
          end else begin
            state <= S_IDLE;
          end
        end
        // Claim a slot or drop the message
        S_MSG: begin
          idx <= '0;
          if (room) begin
            cur_slot              <= new_slot;
            packet_sums[new_slot] <= alu_res;
            tmp                   <= alu_res;
            if (outstanding == '0) begin
              timer_running <= 1'b1;
              timer_count   <= '0;
            end
            state <= S_SEND;
          end else begin
            word_counter <= '0;
            running_sum  <= '0;
            state        <= S_IDLE;
          end
        end
        // Store and emit the new packet one word a cycle while the output is free
        S_SEND: begin
          if (out_free) begin
            seq_number       <= next_sequence[30:0];
            packet_checksum  <= tmp;
            out_payload_word <= send_word;
            word_index       <= idx;
            packet_end       <= (idx == LAST_IDX);
            run_end          <= (idx == LAST_IDX);
            idx              <= idx + IDX_W'(1);
            if (idx == LAST_IDX) begin
              next_sequence <= alu_res;
              outstanding   <= outstanding + CNT_W'(1);
              word_counter  <= '0;
              running_sum   <= '0;
              state         <= S_IDLE;
            end
          end
        end
        S_ACK1: begin
          tmp   <= alu_res;
          state <= S_ACK2;
        end
        // Check the ack sum
        S_ACK2: begin
          word_counter <= '0;
          running_sum  <= '0;
          state        <= (alu_res == achk_r) ? S_ACK3 : S_IDLE;
        end
        // Check the ack lies within the window
        S_ACK3: begin
          tmp   <= alu_res;
          state <= d_ok ? S_ACK4 : S_IDLE;
        end
        // Slide the window
        S_ACK4: begin
          window_base   <= alu_res;
          head_slot     <= new_head;
          outstanding   <= outstanding - tmp[CNT_W-1:0] - CNT_W'(1);
          timer_running <= (outstanding != tmp[CNT_W-1:0] + CNT_W'(1));
          timer_count   <= '0;
          state         <= S_IDLE;
        end
        // Advance the timer, start a resend on expiry
        S_TICK: begin
          if (timer_running && expired) begin
            timer_count <= '0;
            cur_slot    <= head_slot;
            seq_r       <= window_base;
            remaining   <= outstanding;
            idx         <= '0;
            state       <= (outstanding != '0) ? S_RADDR : S_IDLE;
          end else begin
            if (timer_running) begin
              timer_count <= timer_inc;
            end
            state <= S_IDLE;
          end
        end
        S_RADDR: begin
          state <= S_RDATA;
        end
        // Emit one stored word
        S_RDATA: begin
          if (out_free) begin
            seq_number       <= seq_r[30:0];
            packet_checksum  <= packet_sums[cur_slot];
            out_payload_word <= rd_data;
            word_index       <= idx;
            packet_end       <= (idx == LAST_IDX);
            run_end          <= (idx == LAST_IDX) && (remaining == CNT_W'(1));
            if (idx == LAST_IDX) begin
              idx       <= '0;
              seq_r     <= alu_res;
              cur_slot  <= slot_inc;
              remaining <= remaining - CNT_W'(1);
              state     <= (remaining == CNT_W'(1)) ? S_IDLE : S_RADDR;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_RADDR;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/gbn_alu.sv]
// Shared 32-bit add / subtract / increment unit used by the sequencer's arithmetic steps.
// Depends on gbn_pkg.
module gbn_alu import gbn_pkg::*; (
  input  alu_req_t          req,
  output logic [WORD_W-1:0] result
);

  // Pick the operation for this step
  always_comb begin
    unique case (req.op)
      ALU_ADD: result = req.a + req.b;
      ALU_SUB: result = req.a - req.b;
      ALU_INC: result = req.a + WORD_W'(1);
      default: result = req.a;
    endcase
  end

endmodule

[rtl/core/gbn_store.sv]
// Packet word memory: one write port, one read port with registered data.
// Depends on gbn_pkg.
module gbn_store import gbn_pkg::*; #(
  parameter int DEPTH  = 40,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/gbn_checker.sv]
// Port-level checks for the go-back-n sender, bound to the top level.
// Depends on gbn_pkg and go_back_n_sender.
module gbn_props import gbn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] seq_number,
  input logic [31:0] out_payload_word,
  input logic [2:0]  word_index,
  input logic        packet_end,
  input logic        run_end
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(seq_number) &&
    $stable(out_payload_word) && $stable(word_index))
    else $error("stalled result changed");

  // Packet end marks the final word index only
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (packet_end == (word_index == 3'(PAYLOAD_WORDS - 1))))
    else $error("packet_end mismatch");

  // A run always closes on a packet boundary
  a_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_end |-> packet_end)
    else $error("run_end inside packet");

  // Busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("took two items back to back");

endmodule

bind go_back_n_sender gbn_props u_gbn_props (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .seq_number(seq_number),
  .out_payload_word(out_payload_word), .word_index(word_index),
  .packet_end(packet_end), .run_end(run_end)
);
